/* hw/rtl/mono_span_fill_line_store_macros.svh */
// Assertion macros shared by the line store modules.
`ifndef MONO_SPAN_FILL_LINE_STORE_MACROS_SVH
`define MONO_SPAN_FILL_LINE_STORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MSF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/msf_pkg.sv */
// Types and constants of the mono span fill line store.
package msf_pkg;

  // Store geometry
  localparam int ROW_BYTES    = 81;
  localparam int BATCH_ROWS   = 8;
  localparam int SCREEN_WIDTH = 648;
  localparam int STORE_BYTES  = ROW_BYTES * BATCH_ROWS;
  localparam int LIM_COLS     = (SCREEN_WIDTH < ROW_BYTES * 8) ? SCREEN_WIDTH : ROW_BYTES * 8;

  localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int BYTE_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int ROW_W  = (BATCH_ROWS > 1) ? $clog2(BATCH_ROWS) : 1;

  // Working width for coordinate sums: 12-bit signed plus 11-bit unsigned
  localparam int COORD_W = 13;
  localparam logic signed [COORD_W-1:0] LIM_S  = COORD_W'(LIM_COLS);
  localparam logic signed [COORD_W-1:0] ROWS_S = COORD_W'(BATCH_ROWS);

  localparam logic [7:0] MASK_FULL = 8'hFF;
  localparam logic [7:0] BYTE_WHITE = 8'h00;

  // Command queue
  localparam int FQ_DEPTH = 2;
  localparam int FQ_AW    = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;

  // Request codes
  localparam logic [1:0] REQ_PAINT = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Register map
  typedef enum logic [1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_TOP    = 2'd1,
    REG_CLIP_WIDTH  = 2'd2,
    REG_CLIP_HEIGHT = 2'd3
  } reg_idx_t;

  localparam logic signed [11:0] CLIP_LEFT_RST   = 12'sd0;
  localparam logic signed [11:0] CLIP_TOP_RST    = 12'sd0;
  localparam logic [10:0]        CLIP_WIDTH_RST  = 11'd648;
  localparam logic [10:0]        CLIP_HEIGHT_RST = 11'd1;

  typedef struct packed {
    logic signed [11:0] clip_left;
    logic signed [11:0] clip_top;
    logic [10:0]        clip_width;
    logic [10:0]        clip_height;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_PAINT = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_kind_t;

  // Classified command, front to back
  typedef struct packed {
    cmd_kind_t         kind;
    logic              black;
    logic [ADDR_W-1:0] base;      // row base for paint, byte address for read
    logic [BYTE_W-1:0] byte_lo;
    logic [BYTE_W-1:0] byte_hi;
    logic [7:0]        mask_first;
    logic [7:0]        mask_last;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

endpackage

/* hw/rtl/mono_span_fill_line_store.sv */
// Top level of the mono span fill line store: config registers and wiring.
//
// A 1 bpp store of 8 rows x 81 bytes (MSB = leftmost pixel, set = black).
// Request words arrive on the in_ channel (valid/ready): paint a clipped
// horizontal span, read one stored byte, or clear the store to white.
// Every request word gives exactly one result word on the out_ channel:
// out_read_data for reads, out_span_written when a span touched a pixel.
// The clip rectangle and store row origin sit in four APB registers;
// write them only while the block is idle.
// Timing: a request is registered in the front, clipped and queued (two
// entries), then executed by the back, which owns the store's single
// write port. Read: the byte is read in S_RD1 and registered as the
// result in S_RD2. Paint: one read-modify-write per cycle over the
// covered bytes, then S_PFIN. Clear: one byte cleared per cycle. The
// back starts no new command while one is running or a result waits.
// Reset: the back sweeps the whole store to white with in_ready low;
// configuration writes are taken during the sweep.
// A stalled receiver holds the result in the output register; the front
// and queue keep taking up to three more request words meanwhile.
module mono_span_fill_line_store (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic signed [11:0] in_span_x,
  input  logic signed [11:0] in_span_y,
  input  logic [10:0]        in_span_width,
  input  logic               in_paint_black,
  input  logic [9:0]         in_read_index,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_read_data,
  output logic               out_span_written,
  // APB config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import msf_pkg::*;

  cfg_t       cfg_r;
  reg_idx_t   reg_sel;
  back_stat_t bstat;
  cmd_t       push_cmd;
  cmd_t       head_cmd;
  logic       q_push, q_full, q_pop, head_valid;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  // Register writes land on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_left   <= CLIP_LEFT_RST;
      cfg_r.clip_top    <= CLIP_TOP_RST;
      cfg_r.clip_width  <= CLIP_WIDTH_RST;
      cfg_r.clip_height <= CLIP_HEIGHT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_CLIP_LEFT:   cfg_r.clip_left   <= pwdata[11:0];
        REG_CLIP_TOP:    cfg_r.clip_top    <= pwdata[11:0];
        REG_CLIP_WIDTH:  cfg_r.clip_width  <= pwdata[10:0];
        REG_CLIP_HEIGHT: cfg_r.clip_height <= pwdata[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CLIP_LEFT:   prdata = {20'd0, cfg_r.clip_left};
      REG_CLIP_TOP:    prdata = {20'd0, cfg_r.clip_top};
      REG_CLIP_WIDTH:  prdata = {21'd0, cfg_r.clip_width};
      REG_CLIP_HEIGHT: prdata = {21'd0, cfg_r.clip_height};
      default:         prdata = '0;
    endcase
  end

  // Front: take the word, clip, classify
  msf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_span_x      (in_span_x),
    .in_span_y      (in_span_y),
    .in_span_width  (in_span_width),
    .in_paint_black (in_paint_black),
    .in_read_index  (in_read_index),
    .cfg            (cfg_r),
    .bstat          (bstat),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (push_cmd)
  );

  msf_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back: store, byte RMW loop, clear sweep, result register
  msf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (head_valid),
    .q_cmd            (head_cmd),
    .q_pop            (q_pop),
    .bstat            (bstat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_data    (out_read_data),
    .out_span_written (out_span_written)
  );

endmodule

/* hw/rtl/msf_cmd_fifo.sv */
// Short command queue between front and back.
module msf_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  msf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output msf_pkg::cmd_t head_cmd
);
  import msf_pkg::*;

  cmd_t             ent_r [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_ptr_r;
  logic [FQ_AW-1:0] rd_ptr_r;
  logic [FQ_AW:0]   cnt_r;
  logic [FQ_AW:0]   cnt_nxt;

  assign full       = (cnt_r == (FQ_AW+1)'(FQ_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == FQ_AW'(FQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == FQ_AW'(FQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

`include "mono_span_fill_line_store_macros.svh"

  `MSF_ASSERT_IMPL(a_pop_nonempty, pop, cnt_r != '0, "queue popped while empty")

endmodule

/* hw/rtl/msf_front.sv */
// Front end: takes request words, clips spans and queues commands.
module msf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic signed [11:0] in_span_x,
  input  logic signed [11:0] in_span_y,
  input  logic [10:0]        in_span_width,
  input  logic               in_paint_black,
  input  logic [9:0]         in_read_index,
  input  msf_pkg::cfg_t      cfg,
  input  msf_pkg::back_stat_t bstat,
  input  logic               q_full,
  output logic               q_push,
  output msf_pkg::cmd_t      q_cmd
);
  import msf_pkg::*;

  logic               fr_valid_r;
  logic [1:0]         fr_type_r;
  logic signed [11:0] fr_x_r;
  logic signed [11:0] fr_y_r;
  logic [10:0]        fr_w_r;
  logic               fr_black_r;
  logic [9:0]         fr_idx_r;

  logic signed [COORD_W-1:0] x_s, xe_s, cl_s, ce_s, lo_s, hi_s, last_s;
  logic signed [COORD_W-1:0] y_s, ct_s, ch_s, row_s;
  logic                      row_ok, covered;
  logic [ROW_W-1:0]          row_idx;

  assign q_push   = fr_valid_r && !q_full;
  assign in_ready = !bstat.init_busy && (!fr_valid_r || q_push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      fr_valid_r <= 1'b1;
    end else if (q_push) begin
      fr_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fr_type_r  <= in_req_type;
      fr_x_r     <= in_span_x;
      fr_y_r     <= in_span_y;
      fr_w_r     <= in_span_width;
      fr_black_r <= in_paint_black;
      fr_idx_r   <= in_read_index;
    end
  end

  // Clip against rectangle, screen edge and rows held
  always_comb begin
    x_s   = {fr_x_r[11], fr_x_r};
    xe_s  = x_s + {2'b00, fr_w_r};
    cl_s  = {cfg.clip_left[11], cfg.clip_left};
    ce_s  = cl_s + {2'b00, cfg.clip_width};
    y_s   = {fr_y_r[11], fr_y_r};
    ct_s  = {cfg.clip_top[11], cfg.clip_top};
    ch_s  = {2'b00, cfg.clip_height};
    row_s = y_s - ct_s;

    lo_s = (x_s > cl_s) ? x_s : cl_s;
    if (lo_s < 0) begin
      lo_s = '0;
    end
    hi_s = (xe_s < ce_s) ? xe_s : ce_s;
    if (hi_s > LIM_S) begin
      hi_s = LIM_S;
    end
    last_s = hi_s - COORD_W'(1);

    row_ok  = !row_s[COORD_W-1] && (row_s < ROWS_S) && (row_s < ch_s);
    covered = (fr_w_r != '0) && row_ok && (hi_s > lo_s);
    row_idx = row_s[ROW_W-1:0];
  end

  always_comb begin
    q_cmd            = '0;
    q_cmd.kind       = CMD_NONE;
    q_cmd.black      = fr_black_r;
    q_cmd.byte_lo    = BYTE_W'(lo_s >>> 3);
    q_cmd.byte_hi    = BYTE_W'(last_s >>> 3);
    q_cmd.mask_first = MASK_FULL >> lo_s[2:0];
    q_cmd.mask_last  = MASK_FULL << (3'd7 - last_s[2:0]);
    q_cmd.base       = ADDR_W'(32'(row_idx) * ROW_BYTES);
    case (fr_type_r)
      REQ_PAINT: begin
        q_cmd.kind = covered ? CMD_PAINT : CMD_NONE;
      end
      REQ_READ: begin
        q_cmd.kind    = (32'(fr_idx_r) < STORE_BYTES) ? CMD_READ : CMD_NONE;
        q_cmd.base    = ADDR_W'(fr_idx_r);
        q_cmd.byte_lo = '0;
      end
      REQ_CLEAR: begin
        q_cmd.kind = CMD_CLEAR;
      end
      default: begin
        q_cmd.kind = CMD_NONE;
      end
    endcase
  end

endmodule

/* hw/rtl/msf_back.sv */
// Back end: line store memory, span read-modify-write, reads, clear sweep.
module msf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  msf_pkg::cmd_t       q_cmd,
  output logic                q_pop,
  output msf_pkg::back_stat_t bstat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_read_data,
  output logic                out_span_written
);
  import msf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLR   = 6'b000010,
    S_RD1   = 6'b000100,
    S_RD2   = 6'b001000,
    S_PAINT = 6'b010000,
    S_PFIN  = 6'b100000
  } bk_state_t;

  logic [7:0]        mem [STORE_BYTES];

  bk_state_t         state_r;
  logic              wr_pend_r;
  logic              post_clr_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic              out_valid_r;
  logic [7:0]        out_read_data_r;
  logic              out_span_written_r;

  logic [ADDR_W-1:0] base_r;
  logic [BYTE_W-1:0] cnt_r;
  logic [BYTE_W-1:0] byte_lo_r;
  logic [BYTE_W-1:0] byte_hi_r;
  logic [7:0]        mask_first_r;
  logic [7:0]        mask_last_r;
  logic              black_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [7:0]        wr_mask_r;
  logic [7:0]        rd_q_r;

  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        byte_mask;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;

  assign q_pop            = (state_r == S_IDLE) && q_valid && !out_valid_r;
  assign bstat.init_busy  = (state_r == S_CLR) && !post_clr_r;
  assign out_valid        = out_valid_r;
  assign out_read_data    = out_read_data_r;
  assign out_span_written = out_span_written_r;

  assign rd_addr = base_r + ADDR_W'(cnt_r);

  always_comb begin
    byte_mask = MASK_FULL;
    if (cnt_r == byte_lo_r) begin
      byte_mask = byte_mask & mask_first_r;
    end
    if (cnt_r == byte_hi_r) begin
      byte_mask = byte_mask & mask_last_r;
    end
  end

  always_comb begin
    mem_we    = wr_pend_r || (state_r == S_CLR);
    mem_waddr = (state_r == S_CLR) ? clr_cnt_r : wr_addr_r;
    if (state_r == S_CLR) begin
      mem_wdata = BYTE_WHITE;
    end else if (black_r) begin
      mem_wdata = rd_q_r | wr_mask_r;
    end else begin
      mem_wdata = rd_q_r & ~wr_mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q_r <= mem[rd_addr];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      wr_pend_r   <= 1'b0;
      post_clr_r  <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // byte read in a paint cycle is written back the cycle after
      wr_pend_r <= (state_r == S_PAINT);
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            case (q_cmd.kind)
              CMD_READ:  state_r <= S_RD1;
              CMD_PAINT: state_r <= S_PAINT;
              CMD_CLEAR: begin
                state_r    <= S_CLR;
                clr_cnt_r  <= '0;
                post_clr_r <= 1'b1;
              end
              default:   out_valid_r <= 1'b1;
            endcase
          end
        end
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == ADDR_W'(STORE_BYTES - 1)) begin
            state_r    <= S_IDLE;
            post_clr_r <= 1'b0;
            if (post_clr_r) begin
              out_valid_r <= 1'b1;
            end
          end
        end
        S_RD1: begin
          state_r <= S_RD2;
        end
        S_RD2: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
        end
        S_PAINT: begin
          if (cnt_r == byte_hi_r) begin
            state_r <= S_PFIN;
          end
        end
        S_PFIN: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      base_r       <= q_cmd.base;
      cnt_r        <= q_cmd.byte_lo;
      byte_lo_r    <= q_cmd.byte_lo;
      byte_hi_r    <= q_cmd.byte_hi;
      mask_first_r <= q_cmd.mask_first;
      mask_last_r  <= q_cmd.mask_last;
      black_r      <= q_cmd.black;
      out_read_data_r    <= '0;
      out_span_written_r <= 1'b0;
    end
    if (state_r == S_PAINT) begin
      wr_addr_r <= rd_addr;
      wr_mask_r <= byte_mask;
      if (cnt_r != byte_hi_r) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
    if (state_r == S_RD2) begin
      out_read_data_r <= rd_q_r;
    end
    if (state_r == S_PFIN) begin
      out_span_written_r <= 1'b1;
    end
    if (state_r == S_CLR && clr_cnt_r == ADDR_W'(STORE_BYTES - 1)) begin
      out_read_data_r    <= '0;
      out_span_written_r <= 1'b0;
    end
  end

`include "mono_span_fill_line_store_macros.svh"

  `MSF_ASSERT_IMPL(a_pop_slot_free, q_pop, !out_valid_r, "command taken while result pending")
  `MSF_ASSERT_IMPL(a_wr_in_paint, wr_pend_r, (state_r == S_PAINT) || (state_r == S_PFIN), "stray byte write")
  `MSF_ASSERT_NEXT(a_clr_ends, (state_r == S_CLR) && (clr_cnt_r == ADDR_W'(STORE_BYTES - 1)), state_r == S_IDLE, "clear sweep overran")

endmodule
